// File: src/egcd_pkg.sv
// Package for the extended GCD block: microcode word layout, program addresses
// and the read-only program itself. Used by every module of the block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

  localparam int unsigned PC_W = 3;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_START,
    JMP_R_ZERO,
    JMP_CNT_NZ
  } jmp_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_INIT,
    DP_DIV,
    DP_UPD
  } dp_op_e;

  typedef struct packed {
    jmp_e            cond;
    logic [PC_W-1:0] target;
    dp_op_e          op;
    logic            busy;
    logic            done;
  } ctrl_word_t;

  typedef struct packed {
    logic r_zero;
    logic cnt_nz;
  } dp_status_t;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_TEST = 3'd1;
  localparam logic [PC_W-1:0] PC_INIT = 3'd2;
  localparam logic [PC_W-1:0] PC_DIV  = 3'd3;
  localparam logic [PC_W-1:0] PC_UPD  = 3'd4;
  localparam logic [PC_W-1:0] PC_DONE = 3'd5;

  function automatic ctrl_word_t egcd_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      PC_IDLE: cw = '{cond: JMP_NO_START, target: PC_IDLE, op: DP_LOAD, busy: 1'b0, done: 1'b0};
      PC_TEST: cw = '{cond: JMP_R_ZERO,   target: PC_DONE, op: DP_NONE, busy: 1'b1, done: 1'b0};
      PC_INIT: cw = '{cond: JMP_NEVER,    target: PC_IDLE, op: DP_INIT, busy: 1'b1, done: 1'b0};
      PC_DIV:  cw = '{cond: JMP_CNT_NZ,   target: PC_DIV,  op: DP_DIV,  busy: 1'b1, done: 1'b0};
      PC_UPD:  cw = '{cond: JMP_ALWAYS,   target: PC_TEST, op: DP_UPD,  busy: 1'b1, done: 1'b0};
      PC_DONE: cw = '{cond: JMP_ALWAYS,   target: PC_IDLE, op: DP_NONE, busy: 1'b1, done: 1'b1};
      default: cw = '{cond: JMP_ALWAYS,   target: PC_IDLE, op: DP_NONE, busy: 1'b1, done: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// File: src/egcd_seq.sv
// Microcode sequencer for the extended GCD block: step counter, program table
// lookup and conditional jumps. Depends on egcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egcd_seq
  import egcd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output ctrl_word_t      cw_o
);

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  ctrl_word_t      cw;
  logic            take;

  assign cw   = egcd_rom(pc_q);
  assign cw_o = cw;

  always_comb begin
    unique case (cw.cond)
      JMP_NEVER:    take = 1'b0;
      JMP_ALWAYS:   take = 1'b1;
      JMP_NO_START: take = !start_i;
      JMP_R_ZERO:   take = status_i.r_zero;
      JMP_CNT_NZ:   take = status_i.cnt_nz;
      default:      take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: src/egcd_dp.sv
// Datapath of the extended GCD block: remainder and coefficient registers and
// a bit-serial restoring divider that folds the quotient into the coefficient
// updates. Driven by egcd_seq; depends on egcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egcd_dp
  import egcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            start_i,
  input  wire dp_op_e                          op_i,
  input  wire logic [OPERAND_WIDTH-1:0]        operand_x_i,
  input  wire logic [OPERAND_WIDTH-1:0]        operand_y_i,
  output dp_status_t                           status_o,
  output logic [OPERAND_WIDTH-1:0]             gcd_value_o,
  output logic signed [((OPERAND_WIDTH < 64) ? OPERAND_WIDTH + 1 : 64)-1:0] coef_a_o,
  output logic signed [((OPERAND_WIDTH < 64) ? OPERAND_WIDTH + 1 : 64)-1:0] coef_b_o
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CW    = (W < 64) ? W + 1 : 64;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     r_prev_q, r_prev_d, r_cur_q, r_cur_d;
  logic [W-1:0]     rem_q, rem_d, dq_q, dq_d;
  logic [CW-1:0]    s_prev_q, s_prev_d, s_cur_q, s_cur_d;
  logic [CW-1:0]    t_prev_q, t_prev_d, t_cur_q, t_cur_d;
  logic [CW-1:0]    acc_s_q, acc_s_d, acc_t_q, acc_t_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]       shifted;
  logic             qbit;

  assign shifted = {rem_q, dq_q[W-1]};
  assign qbit    = (shifted >= {1'b0, r_cur_q});

  always_comb begin
    r_prev_d = r_prev_q;
    r_cur_d  = r_cur_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    s_prev_d = s_prev_q;
    s_cur_d  = s_cur_q;
    t_prev_d = t_prev_q;
    t_cur_d  = t_cur_q;
    acc_s_d  = acc_s_q;
    acc_t_d  = acc_t_q;
    cnt_d    = cnt_q;
    unique case (op_i)
      DP_LOAD: begin
        if (start_i) begin
          r_prev_d = operand_x_i;
          r_cur_d  = operand_y_i;
          s_prev_d = CW'(1);
          s_cur_d  = '0;
          t_prev_d = '0;
          t_cur_d  = CW'(1);
        end
      end
      DP_INIT: begin
        rem_d   = '0;
        dq_d    = r_prev_q;
        acc_s_d = '0;
        acc_t_d = '0;
        cnt_d   = CNT_W'(W - 1);
      end
      DP_DIV: begin
        rem_d   = qbit ? W'(shifted - {1'b0, r_cur_q}) : shifted[W-1:0];
        dq_d    = {dq_q[W-2:0], qbit};
        acc_s_d = {acc_s_q[CW-2:0], 1'b0} + (qbit ? s_cur_q : '0);
        acc_t_d = {acc_t_q[CW-2:0], 1'b0} + (qbit ? t_cur_q : '0);
        cnt_d   = cnt_q - CNT_W'(1);
      end
      DP_UPD: begin
        r_prev_d = r_cur_q;
        r_cur_d  = rem_q;
        s_prev_d = s_cur_q;
        s_cur_d  = s_prev_q - acc_s_q;
        t_prev_d = t_cur_q;
        t_cur_d  = t_prev_q - acc_t_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    r_prev_q <= r_prev_d;
    r_cur_q  <= r_cur_d;
    rem_q    <= rem_d;
    dq_q     <= dq_d;
    s_prev_q <= s_prev_d;
    s_cur_q  <= s_cur_d;
    t_prev_q <= t_prev_d;
    t_cur_q  <= t_cur_d;
    acc_s_q  <= acc_s_d;
    acc_t_q  <= acc_t_d;
    cnt_q    <= cnt_d;
  end

  assign status_o.r_zero = (r_cur_q == '0);
  assign status_o.cnt_nz = (cnt_q != '0);
  assign gcd_value_o     = r_prev_q;
  assign coef_a_o        = s_prev_q;
  assign coef_b_o        = t_prev_q;

endmodule

`default_nettype wire

// File: src/extended_gcd.sv
// Top level of the extended GCD block: gcd and Bezout coefficients of two
// unsigned operands. Instantiates egcd_seq and egcd_dp; depends on egcd_pkg.
//
//   Channel   Handshake             Beat ports
//   command   start_i / busy_o      operand_x_i, operand_y_i
//   result    done_o (one cycle)    gcd_value_o, coef_a_o, coef_b_o
//
// A beat is taken when start_i is high and busy_o is low. Each Euclid step
// runs the divider, which yields one quotient bit per cycle; an item runs
// Euclid steps until the remainder is zero and then shows the result. The
// result is shown for the single cycle done_o is high and the receiver
// cannot stall it. After reset the block is idle at once.
`timescale 1ns / 1ps
`default_nettype none

module extended_gcd
  import egcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [OPERAND_WIDTH-1:0] operand_x_i,
  input  wire logic [OPERAND_WIDTH-1:0] operand_y_i,
  output logic                          done_o,
  output logic [OPERAND_WIDTH-1:0]      gcd_value_o,
  output logic signed [((OPERAND_WIDTH < 64) ? OPERAND_WIDTH + 1 : 64)-1:0] coef_a_o,
  output logic signed [((OPERAND_WIDTH < 64) ? OPERAND_WIDTH + 1 : 64)-1:0] coef_b_o
);

  ctrl_word_t cw;
  dp_status_t status;

  egcd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cw_o     (cw)
  );

  egcd_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .start_i     (start_i),
    .op_i        (cw.op),
    .operand_x_i (operand_x_i),
    .operand_y_i (operand_y_i),
    .status_o    (status),
    .gcd_value_o (gcd_value_o),
    .coef_a_o    (coef_a_o),
    .coef_b_o    (coef_b_o)
  );

  assign busy_o = cw.busy;
  assign done_o = cw.done;

endmodule

`default_nettype wire

// File: dv/extended_gcd_tb.sv
// Testbench for extended_gcd: sends operand pairs through the start/busy command
// port and checks each gcd and Bezout coefficient beat against its own forward Euclid predictor.
// Depends only on the extended_gcd RTL and egcd_pkg.
`timescale 1ns / 1ps

module extended_gcd_tb;

  localparam int unsigned OP_W        = 32;
  localparam int unsigned COEF_W      = OP_W + 1;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned CALM_ITEMS  = 120;
  localparam int unsigned IDLE_PCT    = 27;
  localparam logic [OP_W-1:0] OP_MAX  = '1;
  localparam logic [OP_W-1:0] FIB_46  = 32'd1836311903;
  localparam logic [OP_W-1:0] FIB_47  = 32'd2971215073;

  typedef struct packed {
    logic [OP_W-1:0]   gcd;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
  } bezout_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          operand_x_i;
  logic [OP_W-1:0]          operand_y_i;
  logic                     done_o;
  logic [OP_W-1:0]          gcd_value_o;
  logic signed [COEF_W-1:0] coef_a_o;
  logic signed [COEF_W-1:0] coef_b_o;

  bezout_t pending_bezout[$];
  int      mismatch_count = 0;
  int      quiet_cycles = 0;
  bit      gaps_on = 1'b0;

  extended_gcd #(
    .OPERAND_WIDTH(OP_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .operand_x_i(operand_x_i),
    .operand_y_i(operand_y_i),
    .done_o     (done_o),
    .gcd_value_o(gcd_value_o),
    .coef_a_o   (coef_a_o),
    .coef_b_o   (coef_b_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Forward Euclid with coefficients kept modulo 2^64; the truncation is exact.
  function automatic bezout_t predict_bezout(input logic [OP_W-1:0] x, input logic [OP_W-1:0] y);
    logic [63:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur, quo, tmp;
    bezout_t     res;
    r_prev = 64'(x);
    r_cur  = 64'(y);
    s_prev = 64'd1;
    s_cur  = 64'd0;
    t_prev = 64'd0;
    t_cur  = 64'd1;
    while (r_cur != 64'd0) begin
      quo    = r_prev / r_cur;
      tmp    = r_prev - quo * r_cur;
      r_prev = r_cur;
      r_cur  = tmp;
      tmp    = s_prev - quo * s_cur;
      s_prev = s_cur;
      s_cur  = tmp;
      tmp    = t_prev - quo * t_cur;
      t_prev = t_cur;
      t_cur  = tmp;
    end
    res.gcd    = r_prev[OP_W-1:0];
    res.coef_a = s_prev[COEF_W-1:0];
    res.coef_b = t_prev[COEF_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Called and left at a falling edge; start_i stays high across back-to-back beats.
  task automatic issue_operands(input logic [OP_W-1:0] x, input logic [OP_W-1:0] y);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1700) : $urandom_range(1, 6);
      start_i     <= 1'b0;
      operand_x_i <= $urandom;
      operand_y_i <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    operand_x_i <= x;
    operand_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    pending_bezout.push_back(predict_bezout(x, y));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    bezout_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (done_o) begin
        if (pending_bezout.size() == 0) begin
          report_mismatch("result with no pending beat", longint'(gcd_value_o), 0);
        end else begin
          want = pending_bezout.pop_front();
          if (gcd_value_o !== want.gcd)
            report_mismatch("gcd_value", longint'(gcd_value_o), longint'(want.gcd));
          if (coef_a_o !== want.coef_a)
            report_mismatch("coef_a", longint'(coef_a_o), longint'($signed(want.coef_a)));
          if (coef_b_o !== want.coef_b)
            report_mismatch("coef_b", longint'(coef_b_o), longint'($signed(want.coef_b)));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL extended_gcd");
        $finish;
      end
    end
  end

  task automatic test_zero_operands();
    issue_operands('0, '0);
    issue_operands(32'd12345, '0);
    issue_operands('0, 32'd6789);
    issue_operands(OP_MAX, '0);
    issue_operands('0, OP_MAX);
    issue_operands(32'd1, '0);
    issue_operands('0, 32'd1);
  endtask

  task automatic test_extreme_operands();
    issue_operands(OP_MAX, OP_MAX);
    issue_operands(OP_MAX, OP_MAX - 1);
    issue_operands(OP_MAX, 32'd1);
    issue_operands(32'd1, OP_MAX);
    issue_operands(32'd1, 32'd1);
    issue_operands(FIB_47, FIB_46);
    issue_operands(FIB_46, FIB_47);
    issue_operands(32'h8000_0000, 32'h4000_0000);
    issue_operands(32'hAAAA_AAAA, 32'h5555_5555);
    issue_operands(32'd240, 32'd46);
    issue_operands(32'd46, 32'd240);
    issue_operands(OP_MAX, 32'h8000_0000);
  endtask

  task automatic test_random_operands();
    logic [OP_W-1:0] x, y, scale;
    logic [63:0]     fib_lo, fib_hi, fib_tmp;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = (n >= CALM_ITEMS);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x = $urandom;
          y = $urandom;
        end
        4: begin
          scale = $urandom_range(1, 65535);
          x = scale * $urandom_range(0, 65535);
          y = scale * $urandom_range(0, 65535);
        end
        5: begin
          x = $urandom_range(0, 255);
          y = $urandom_range(0, 255);
        end
        6: begin
          fib_lo = 64'd0;
          fib_hi = 64'd1;
          repeat ($urandom_range(1, 46)) begin
            fib_tmp = fib_lo + fib_hi;
            fib_lo  = fib_hi;
            fib_hi  = fib_tmp;
          end
          if ($urandom_range(0, 1)) begin
            x = fib_hi[OP_W-1:0];
            y = fib_lo[OP_W-1:0];
          end else begin
            x = fib_lo[OP_W-1:0];
            y = fib_hi[OP_W-1:0];
          end
        end
        7: begin
          x = $urandom;
          y = '0;
          if ($urandom_range(0, 1)) begin
            y = x;
            x = '0;
          end
        end
        8: begin
          y = $urandom_range(1, 65535);
          x = y * $urandom_range(0, 65535);
        end
        default: begin
          x = $urandom >> $urandom_range(0, 31);
          y = $urandom >> $urandom_range(0, 31);
        end
      endcase
      issue_operands(x, y);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operand_x_i = '0;
    operand_y_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    gaps_on = 1'b1;
    test_zero_operands();
    test_extreme_operands();
    test_random_operands();
    start_i <= 1'b0;
    wait (pending_bezout.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS extended_gcd");
    end else begin
      $display("FAIL extended_gcd");
    end
    $finish;
  end

endmodule

// File: extended_gcd.f
src/egcd_pkg.sv
src/egcd_seq.sv
src/egcd_dp.sv
src/extended_gcd.sv
dv/extended_gcd_tb.sv
